### rtl/nonzero_window_average_macros.svh
// assertion helpers, clocked on clk_i and quiet while rst_ni is low
`ifndef NONZERO_WINDOW_AVERAGE_MACROS_SVH
`define NONZERO_WINDOW_AVERAGE_MACROS_SVH

// same-cycle implication
`define NWA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NWA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/nwa_pkg.sv
`timescale 1ns / 1ps

package nwa_pkg;

  localparam int unsigned AverageBits = 12;
  localparam int unsigned CountBits   = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } nwa_state_e;

endpackage

### rtl/nwa_ram.sv
`timescale 1ns / 1ps

module nwa_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 30,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/nwa_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module nwa_div #(
  parameter int unsigned NUM_W = 17,
  parameter int unsigned DEN_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quotient_o
);

  localparam int unsigned StepW = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = StepW'(NUM_W);
      rem_d  = '0;
      den_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_d  = {quo_q[NUM_W-2:0], fits};
      step_d = step_q - StepW'(1);
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### rtl/nonzero_window_average.sv
`timescale 1ns / 1ps
`include "nonzero_window_average_macros.svh"

// Moving average over the last WINDOW_LEN samples, zero samples left out.
// Input channel: sample_i with in_valid_i / in_stall_o; one item per sample.
// Output channel: average_o and nonzero_count_o with out_valid_o / out_stall_i,
// exactly one result item per input item, in order.
// Each item reads the overwritten ring entry, updates the running sum and
// nonzero count, then divides sum by count in the restoring divider
// that makes one quotient bit per cycle. That divider loop sets the rate:
// the next item is taken only once the result of the last one has been
// loaded into the output register. When the window holds no nonzero entry
// the divider is skipped, the average is zero and the state goes from load
// straight to done. in_stall_o is high while an item is being worked on.
// The result sits in an output register; if the receiver stalls, a
// finished result waits there and the next item may still be accepted
// and worked on, holding before its own hand-off.
// Reset clears the ring (through per-entry valid bits), the write slot,
// the running sum and count, and drops any pending result.
module nonzero_window_average #(
  parameter int unsigned WINDOW_LEN  = 30,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [11:0]                    sample_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [nwa_pkg::AverageBits-1:0] average_o,
  output logic [nwa_pkg::CountBits-1:0]   nonzero_count_o
);

  import nwa_pkg::*;

  localparam int unsigned IdxW  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned CntW  = $clog2(WINDOW_LEN + 1);
  localparam int unsigned SumW  = SAMPLE_BITS + CntW;
  localparam int unsigned SampW = 12;

  nwa_state_e state_q, state_d;

  logic                   accept;
  logic                   div_start;
  logic                   ram_we;
  logic                   load_out;
  logic                   skip_div;

  logic [SAMPLE_BITS-1:0] sample_q;
  logic [IdxW-1:0]        slot_q, slot_d;
  logic [WINDOW_LEN-1:0]  entry_vld_q, entry_vld_d;
  logic                   old_vld_q;
  logic [SumW-1:0]        sum_q, sum_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [SumW-1:0]        res_q;
  logic                   out_valid_q;
  logic [AverageBits-1:0] avg_q;
  logic [CountBits-1:0]   cnt_out_q;

  logic [SAMPLE_BITS+SampW-1:0] sample_ext;
  logic [SAMPLE_BITS-1:0]       fresh;
  logic [SAMPLE_BITS-1:0]       rd_data;
  logic [SAMPLE_BITS-1:0]       old_val;
  logic                         div_done;
  logic [SumW-1:0]              quotient;
  logic [SumW+AverageBits-1:0]  avg_ext;
  logic [CntW+CountBits-1:0]    cnt_ext;

  // keep only the low SAMPLE_BITS bits of the converter reading
  assign sample_ext = {{SAMPLE_BITS{1'b0}}, sample_i};
  assign fresh      = sample_ext[SAMPLE_BITS-1:0];

  assign accept   = in_valid_i && !in_stall_o;
  assign old_val  = old_vld_q ? rd_data : '0;
  assign skip_div = (cnt_d == '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = skip_div ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    ram_we     = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_LOAD: begin
        ram_we    = 1'b1;
        div_start = !skip_div;
      end
      ST_DIV:  ;
      ST_DONE: load_out = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  // running sum and count: drop the overwritten entry, add the new one
  always_comb begin
    sum_d       = sum_q - SumW'(old_val) + SumW'(sample_q);
    cnt_d       = cnt_q - CntW'(old_val != '0) + CntW'(sample_q != '0);
    slot_d      = (slot_q == IdxW'(WINDOW_LEN - 1)) ? '0 : slot_q + IdxW'(1);
    entry_vld_d = entry_vld_q;
    entry_vld_d[slot_q] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      entry_vld_q <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ram_we) begin
        slot_q      <= slot_d;
        entry_vld_q <= entry_vld_d;
        sum_q       <= sum_d;
        cnt_q       <= cnt_d;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q  <= fresh;
      old_vld_q <= entry_vld_q[slot_q];
    end
    if (ram_we && skip_div) begin
      res_q <= '0;
    end else if (div_done) begin
      res_q <= quotient;
    end
    if (load_out) begin
      avg_q     <= avg_ext[AverageBits-1:0];
      cnt_out_q <= cnt_ext[CountBits-1:0];
    end
  end

  assign avg_ext = {{AverageBits{1'b0}}, res_q};
  assign cnt_ext = {{CountBits{1'b0}}, cnt_q};

  nwa_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_LEN)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (sample_q),
    .re_i    (accept),
    .raddr_i (slot_q),
    .rdata_o (rd_data)
  );

  nwa_div #(
    .NUM_W (SumW),
    .DEN_W (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .divisor_i  (cnt_d),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign out_valid_o     = out_valid_q;
  assign average_o       = avg_q;
  assign nonzero_count_o = cnt_out_q;

  `NWA_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= CntW'(WINDOW_LEN), "nonzero count above window")
  `NWA_ASSERT_NOW(a_empty_sum, cnt_q == '0, sum_q == '0, "sum nonzero with empty window")
  `NWA_ASSERT_NEXT(a_accept_load, accept, state_q == ST_LOAD, "accepted item not loaded")
  `NWA_ASSERT_NOW(a_div_done, div_done, state_q == ST_DIV, "divider done outside divide")
  `NWA_ASSERT_NEXT(a_hold_result, state_q == ST_DONE && out_valid_q && out_stall_i,
                   state_q == ST_DONE, "result left while output stalled")

endmodule

### test/nonzero_window_average_tb.sv
`timescale 1ns / 1ps

module nonzero_window_average_tb;

  import nwa_pkg::*;

  localparam int unsigned WindowLen   = 30;
  localparam int unsigned TargetItems = 1200;
  localparam logic [11:0] SampleMax   = 12'hFFF;

  typedef enum int unsigned {
    SEG_MIXED,
    SEG_FULL_SCALE,
    SEG_ALL_ZERO,
    SEG_SPARSE,
    SEG_TINY,
    SEG_RAW
  } seg_kind_e;

  typedef struct {
    logic [11:0] value;
    int unsigned gap;
    bit          drain;
  } sample_item_t;

  typedef struct packed {
    logic [AverageBits-1:0] average;
    logic [CountBits-1:0]   count;
  } window_result_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic [11:0]            sample_i    = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [AverageBits-1:0] average_o;
  logic [CountBits-1:0]   nonzero_count_o;

  sample_item_t   pending_q[$];
  window_result_t expected_q[$];

  // predictor copy of the window
  logic [11:0] ring_model [WindowLen];
  int unsigned slot_model;
  logic [16:0] sum_model;
  logic [4:0]  count_model;

  sample_item_t nxt_item;
  int unsigned  gap_left;
  int unsigned  stall_left;
  int unsigned  cycle_cnt;
  int unsigned  items_sent;
  int unsigned  results_seen;
  int unsigned  empty_results;
  int unsigned  full_results;
  int unsigned  mismatches;
  int unsigned  generated;

  nonzero_window_average u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .average_o      (average_o),
    .nonzero_count_o(nonzero_count_o)
  );

  always #5 clk_i = ~clk_i;

  // write one sample into the window and return the new average and count
  function automatic window_result_t slide_window(logic [11:0] fresh);
    window_result_t res;
    logic [11:0]    old;
    old = ring_model[slot_model];
    if (old != 0) begin
      sum_model   = sum_model - 17'(old);
      count_model = count_model - 5'd1;
    end
    if (fresh != 0) begin
      sum_model   = sum_model + 17'(fresh);
      count_model = count_model + 5'd1;
    end
    ring_model[slot_model] = fresh;
    slot_model = (slot_model + 1 >= WindowLen) ? 0 : slot_model + 1;
    res.count = count_model;
    if (count_model != 0) begin
      res.average = AverageBits'(sum_model / 17'(count_model));
    end else begin
      res.average = '0;
    end
    return res;
  endfunction

  // mostly short pauses, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 20);
    end
    return $urandom_range(30, 80);
  endfunction

  task automatic queue_sample(logic [11:0] value, bit calm, bit drain);
    sample_item_t it;
    it.value = value;
    it.gap   = calm ? 0 : pick_gap();
    it.drain = drain;
    pending_q.push_back(it);
    generated++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sample_i   <= '0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_q.push_back(slide_window(sample_i));
        items_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].drain && expected_q.size() != 0)) begin
          nxt_item   = pending_q.pop_front();
          in_valid_i <= 1'b1;
          sample_i   <= nxt_item.value;
          gap_left   <= nxt_item.gap;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
      cycle_cnt   <= 0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with nothing expected: average %0d count %0d",
                     $realtime, average_o, nonzero_count_o);
          end
        end else begin
          window_result_t want;
          want = expected_q.pop_front();
          if (want.count == 0) empty_results++;
          if (want.count == 5'(WindowLen)) full_results++;
          if (average_o !== want.average || nonzero_count_o !== want.count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result %0d: average exp %0d got %0d, count exp %0d got %0d",
                       $realtime, results_seen, want.average, average_o,
                       want.count, nonzero_count_o);
            end
          end
        end
      end
      // in the first third of each stall period the receiver starts no new stall
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else if ((cycle_cnt % 6000) >= 2000 && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= pick_gap();
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    seg_kind_e   kind;
    int unsigned len;
    bit          calm;
    logic [11:0] v;

    for (int i = 0; i < WindowLen; i++) ring_model[i] = '0;
    slot_model  = 0;
    sum_model   = '0;
    count_model = '0;

    // directed: empty window, extremes, alternating bit patterns
    queue_sample(12'd0, 1'b0, 1'b0);
    queue_sample(SampleMax, 1'b0, 1'b0);
    queue_sample(12'd1, 1'b0, 1'b0);
    queue_sample(12'd0, 1'b0, 1'b0);
    queue_sample(12'd2, 1'b1, 1'b0);
    queue_sample(12'hAAA, 1'b1, 1'b0);
    queue_sample(12'h555, 1'b0, 1'b0);
    queue_sample(SampleMax, 1'b1, 1'b0);
    queue_sample(SampleMax, 1'b1, 1'b0);
    queue_sample(12'h800, 1'b0, 1'b0);
    queue_sample(12'd3, 1'b0, 1'b0);
    queue_sample(12'h7FF, 1'b0, 1'b0);
    queue_sample(12'd0, 1'b0, 1'b0);
    queue_sample(12'd0, 1'b0, 1'b0);

    // random: runs long enough to fill, empty and churn the window
    while (generated < TargetItems) begin
      kind = seg_kind_e'($urandom_range(0, 5));
      len  = $urandom_range(20, 45);
      calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
        case (kind)
          SEG_MIXED: begin
            v = ($urandom_range(0, 7) == 0) ? 12'd0 : 12'($urandom_range(1, 4095));
          end
          SEG_FULL_SCALE: begin
            v = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(4000, 4095)) : SampleMax;
          end
          SEG_ALL_ZERO: begin
            v = 12'd0;
          end
          SEG_SPARSE: begin
            v = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(1, 4095)) : 12'd0;
          end
          SEG_TINY: begin
            v = 12'($urandom_range(0, 7));
          end
          default: begin
            v = 12'($urandom_range(0, 4095));
          end
        endcase
        queue_sample(v, calm,
                     i == 0 && (generated < 40 || $urandom_range(0, 5) == 0));
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || in_valid_i || expected_q.size() != 0 ||
           items_sent < generated) begin
      @(posedge clk_i);
    end
    // let any stray result surface
    repeat (40) @(posedge clk_i);

    $display("sent %0d samples, checked %0d results (%0d with an empty window, %0d full)",
             items_sent, results_seen, empty_results, full_results);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("PASS nonzero_window_average");
    end else begin
      $display("FAIL nonzero_window_average");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout with %0d results still expected", expected_q.size());
    $display("FAIL nonzero_window_average");
    $finish;
  end

endmodule

### nonzero_window_average.f
+incdir+rtl
rtl/nwa_pkg.sv
rtl/nwa_ram.sv
rtl/nwa_div.sv
rtl/nonzero_window_average.sv
test/nonzero_window_average_tb.sv
